FILE: hw/rtl/qam_hard_decision_demapper_assert.svh
`ifndef QAM_HARD_DECISION_DEMAPPER_ASSERT_SVH
`define QAM_HARD_DECISION_DEMAPPER_ASSERT_SVH

// clocked check, disabled while reset is low
`define QHD_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define QHD_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/qhd_pkg.sv
package qhd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 13;

    localparam int ORDER_W  = 2;
    localparam int INDEX_W  = 6;
    localparam int BPS_W    = 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [ORDER_W-1:0] ORDER_QAM4  = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_QAM16 = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_QAM64 = 2'd2;

    localparam logic [ADDR_W-3:0] REG_QAM_ORDER = 1'd0;

    localparam logic [BPS_W-1:0] BPS_QAM4  = 3'd2;
    localparam logic [BPS_W-1:0] BPS_QAM16 = 3'd4;
    localparam logic [BPS_W-1:0] BPS_QAM64 = 3'd6;

    localparam int K_QAM4    = 2;
    localparam int K_QAM16   = 4;
    localparam int K_QAM64   = 8;
    localparam int DEN_QAM4  = 2;
    localparam int DEN_QAM16 = 10;
    localparam int DEN_QAM64 = 42;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] rx_i;
        logic signed [SAMPLE_WIDTH-1:0] rx_q;
    } t_rx_sample;

    typedef struct packed {
        logic [INDEX_W-1:0] symbol_index;
        logic [BPS_W-1:0]   bits_per_symbol;
    } t_decision;

    // round(mag * 2^frac / sqrt(den)) by a bitwise root search, no division
    function automatic longint level_mag(int frac, int mag, int den);
        logic [127:0] t;
        logic [127:0] sq;
        logic [63:0]  s;
        logic [63:0]  c;
        t = 128'(mag * mag) << (2 * frac + 2);
        s = '0;
        for (int b = 40; b >= 0; b--) begin
            c  = s | (64'd1 << b);
            sq = 128'(c) * 128'(c) * 128'(den);
            if (sq <= t) begin
                s = c;
            end
        end
        return longint'((s + 64'd1) >> 1);
    endfunction

    function automatic longint level(int frac, int k, int den, int a);
        int lv;
        lv = 2 * a - k + 1;
        if (lv < 0) begin
            return -level_mag(frac, -lv, den);
        end
        return level_mag(frac, lv, den);
    endfunction

    // twice the midpoint between levels j and j+1
    function automatic longint threshold(int frac, int k, int den, int j);
        return level(frac, k, den, j) + level(frac, k, den, j + 1);
    endfunction

endpackage

FILE: hw/rtl/qam_hard_decision_demapper.sv
// channel   | ports                            | transfer
// ----------+----------------------------------+------------------------------------
// sample in | start, busy, i_sample            | edge with start high, busy low
// decision  | o_done, o_result                 | edge ending the cycle o_done is high
// config    | psel, penable, pwrite, paddr ... | edge with psel, penable, pwrite high
//
// One sample per cycle; busy never rises. Each decision passes through the input register,
// the per-axis threshold compare and the result register.
// Synchronous reset clears the valid flags and sets qam_order to 4-QAM.
// The decision strobe cannot be held off.
`include "qam_hard_decision_demapper_assert.svh"

module qam_hard_decision_demapper #(
    parameter int FRAC_BITS = qhd_pkg::FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  qhd_pkg::t_rx_sample             i_sample,
    output logic                            o_done,
    output qhd_pkg::t_decision              o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qhd_pkg::ADDR_W-1:0]      paddr,
    input  logic [qhd_pkg::DATA_W-1:0]      pwdata,
    output logic [qhd_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int SW = qhd_pkg::SAMPLE_WIDTH;
    localparam int CW = ((SW > FRAC_BITS + 3) ? SW : FRAC_BITS + 3) + 2;

    logic [qhd_pkg::ORDER_W-1:0] r_qam_order;
    logic                        r_in_valid;
    qhd_pkg::t_rx_sample         r_in;
    logic                        r_done;
    qhd_pkg::t_decision          r_result;
    qhd_pkg::t_decision          n_result;
    logic                        w_accept;
    logic                        w_reg_hit;
    logic signed [CW-1:0]        w_xi2;
    logic signed [CW-1:0]        w_xq2;
    logic [0:0]                  w_gt4_i;
    logic [0:0]                  w_gt4_q;
    logic [2:0]                  w_gt16_i;
    logic [2:0]                  w_gt16_q;
    logic [6:0]                  w_gt64_i;
    logic [6:0]                  w_gt64_q;
    logic [1:0]                  w_a16_i;
    logic [1:0]                  w_a16_q;
    logic [2:0]                  w_a64_i;
    logic [2:0]                  w_a64_q;
    logic                        w_bps_legal;
    logic                        w_index_fits;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start && !busy;
    assign w_reg_hit = (paddr[qhd_pkg::ADDR_W-1:2] == qhd_pkg::REG_QAM_ORDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qam_order <= qhd_pkg::ORDER_QAM4;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_qam_order <= pwdata[qhd_pkg::ORDER_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_hit) begin
            prdata = {{(qhd_pkg::DATA_W - qhd_pkg::ORDER_W){1'b0}}, r_qam_order};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
            r_done     <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_sample;
        end
        r_result <= n_result;
    end

    assign w_xi2 = {{(CW - 1 - SW){r_in.rx_i[SW-1]}}, r_in.rx_i, 1'b0};
    assign w_xq2 = {{(CW - 1 - SW){r_in.rx_q[SW-1]}}, r_in.rx_q, 1'b0};

    for (genvar j = 0; j < 1; j++) begin : g_th4
        localparam logic signed [CW-1:0] TH = CW'(qhd_pkg::threshold(
            FRAC_BITS, qhd_pkg::K_QAM4, qhd_pkg::DEN_QAM4, j));
        assign w_gt4_i[j] = (w_xi2 > TH);
        assign w_gt4_q[j] = (w_xq2 > TH);
    end

    for (genvar j = 0; j < 3; j++) begin : g_th16
        localparam logic signed [CW-1:0] TH = CW'(qhd_pkg::threshold(
            FRAC_BITS, qhd_pkg::K_QAM16, qhd_pkg::DEN_QAM16, j));
        assign w_gt16_i[j] = (w_xi2 > TH);
        assign w_gt16_q[j] = (w_xq2 > TH);
    end

    for (genvar j = 0; j < 7; j++) begin : g_th64
        localparam logic signed [CW-1:0] TH = CW'(qhd_pkg::threshold(
            FRAC_BITS, qhd_pkg::K_QAM64, qhd_pkg::DEN_QAM64, j));
        assign w_gt64_i[j] = (w_xi2 > TH);
        assign w_gt64_q[j] = (w_xq2 > TH);
    end

    assign w_a16_i = 2'($countones(w_gt16_i));
    assign w_a16_q = 2'($countones(w_gt16_q));
    assign w_a64_i = 3'($countones(w_gt64_i));
    assign w_a64_q = 3'($countones(w_gt64_q));

    always_comb begin
        unique case (r_qam_order)
            qhd_pkg::ORDER_QAM4: begin
                n_result.symbol_index    = {4'd0, w_gt4_i, w_gt4_q};
                n_result.bits_per_symbol = qhd_pkg::BPS_QAM4;
            end
            qhd_pkg::ORDER_QAM16: begin
                n_result.symbol_index    = {2'd0, w_a16_i, w_a16_q};
                n_result.bits_per_symbol = qhd_pkg::BPS_QAM16;
            end
            default: begin
                n_result.symbol_index    = {w_a64_i, w_a64_q};
                n_result.bits_per_symbol = qhd_pkg::BPS_QAM64;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    assign w_bps_legal  = (o_result.bits_per_symbol == qhd_pkg::BPS_QAM4)
                       || (o_result.bits_per_symbol == qhd_pkg::BPS_QAM16)
                       || (o_result.bits_per_symbol == qhd_pkg::BPS_QAM64);
    assign w_index_fits = ((o_result.symbol_index >> o_result.bits_per_symbol) == '0);

    `QHD_CHECK(a_latency, i_clk, i_rst_n, w_accept |-> ##2 o_done, "decision missing")
    `QHD_CHECK(a_bps_legal, i_clk, i_rst_n, o_done |-> w_bps_legal, "bad bit count")
    `QHD_CHECK(a_index_fits, i_clk, i_rst_n, o_done |-> w_index_fits, "index too wide")
    `QHD_CHECK_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_done && !r_in_valid, "strobe in reset")

endmodule

FILE: dv/qhd_decision_checker.sv
`timescale 1ns / 100ps

module qhd_decision_checker
    import qhd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_rx_sample           i_sample,
    input  logic                 i_done,
    input  t_decision            i_result,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [ADDR_W-1:0]    i_paddr,
    input  logic [DATA_W-1:0]    i_pwdata,
    input  logic [DATA_W-1:0]    i_prdata,
    input  logic                 i_pready,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_decisions
);

    localparam logic [ADDR_W-1:0] ORDER_ADDR = {REG_QAM_ORDER, 2'b00};

    longint             level_tab [3][8];
    logic [ORDER_W-1:0] order_q;
    t_decision          decisions_due [$];
    t_decision          want;
    int                 mismatches = 0;
    int                 decisions = 0;

    assign o_mismatches = mismatches;
    assign o_decisions  = decisions;

    function automatic longint unsigned root_floor(longint unsigned q);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= q) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic longint point_level(int k, int den, int a);
        int              lv;
        longint unsigned mag;
        longint unsigned s;
        lv  = 2 * a - k + 1;
        mag = longint'((lv < 0) ? -lv : lv);
        s   = root_floor(((mag * mag) << (2 * FRAC_BITS + 2)) / longint'(den));
        s   = (s + 1) >> 1;
        return (lv < 0) ? -longint'(s) : longint'(s);
    endfunction

    initial begin
        for (int a = 0; a < 8; a++) begin
            level_tab[0][a] = (a < K_QAM4)  ? point_level(K_QAM4,  DEN_QAM4,  a) : 0;
            level_tab[1][a] = (a < K_QAM16) ? point_level(K_QAM16, DEN_QAM16, a) : 0;
            level_tab[2][a] = point_level(K_QAM64, DEN_QAM64, a);
        end
    end

    // lowest level wins on a tie
    function automatic int axis_pick(longint x, int row, int k);
        longint diff;
        longint d;
        longint best_d;
        int     best;
        best   = 0;
        best_d = 0;
        for (int a = 0; a < k; a++) begin
            diff = x - level_tab[row][a];
            d    = diff * diff;
            if (a == 0 || d < best_d) begin
                best_d = d;
                best   = a;
            end
        end
        return best;
    endfunction

    function automatic t_decision nearest_symbol(t_rx_sample s, logic [ORDER_W-1:0] order);
        t_decision d;
        int        rank;
        int        ai;
        int        aq;
        case (order)
            ORDER_QAM4: begin
                rank              = 1;
                d.bits_per_symbol = BPS_QAM4;
            end
            ORDER_QAM16: begin
                rank              = 2;
                d.bits_per_symbol = BPS_QAM16;
            end
            default: begin
                rank              = 3;
                d.bits_per_symbol = BPS_QAM64;
            end
        endcase
        ai = axis_pick(longint'($signed(s.rx_i)), rank - 1, 1 << rank);
        aq = axis_pick(longint'($signed(s.rx_q)), rank - 1, 1 << rank);
        d.symbol_index = INDEX_W'((ai << rank) | aq);
        return d;
    endfunction

    task automatic report(string what, longint got, longint exp_val);
        mismatches++;
        if (mismatches <= 40) begin
            $display("tb: mismatch on %s: got %0d, expected %0d at %0t",
                     what, got, exp_val, $realtime);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            order_q <= ORDER_QAM4;
            decisions_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == ORDER_ADDR) begin
                        order_q <= i_pwdata[ORDER_W-1:0];
                    end
                end else if (i_prdata != DATA_W'(order_q)) begin
                    report("qam_order read", longint'(i_prdata), longint'(order_q));
                end
            end
            if (i_start && !i_busy) begin
                decisions_due.insert(decisions_due.size(), nearest_symbol(i_sample, order_q));
            end
            if (i_done) begin
                if (decisions_due.size() == 0) begin
                    report("decision with none due", longint'(i_result.symbol_index), -1);
                end else begin
                    want = decisions_due.pop_front();
                    decisions++;
                    if (i_result.symbol_index != want.symbol_index) begin
                        report("symbol_index", longint'(i_result.symbol_index),
                               longint'(want.symbol_index));
                    end
                    if (i_result.bits_per_symbol != want.bits_per_symbol) begin
                        report("bits_per_symbol", longint'(i_result.bits_per_symbol),
                               longint'(want.bits_per_symbol));
                    end
                end
            end
        end
        o_pending <= decisions_due.size();
    end

endmodule

FILE: dv/qam_hard_decision_demapper_test.sv
`timescale 1ns / 100ps

module qam_hard_decision_demapper_test;
    import qhd_pkg::*;

    localparam int          PHASES     = 8;
    localparam int          PHASE_LEN  = 50;
    localparam int unsigned QUIET_MAX  = 2000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_rx_sample         i_sample;
    logic               o_done;
    t_decision          o_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 mismatches;
    int                 pending;
    int                 decisions;
    int                 samples_sent = 0;
    int                 settings = 0;
    logic [3:0]         orders_seen = '0;
    int unsigned        quiet = 0;

    qam_hard_decision_demapper DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_sample (i_sample),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    qhd_decision_checker decision_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_sample     (i_sample),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_decisions  (decisions)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable && pready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_MAX) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // half the doubled midpoint between levels j and j+1, plus an offset
    function automatic logic signed [SAMPLE_WIDTH-1:0] near_cut(int rank, int j, int off);
        longint t;
        case (rank)
            1:       t = threshold(FRAC_BITS, K_QAM4,  DEN_QAM4,  j);
            2:       t = threshold(FRAC_BITS, K_QAM16, DEN_QAM16, j);
            default: t = threshold(FRAC_BITS, K_QAM64, DEN_QAM64, j);
        endcase
        return SAMPLE_WIDTH'((t >>> 1) + off);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_axis(int rank);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return SAMPLE_WIDTH'($urandom());
        end else if (pick < 8) begin
            return SAMPLE_WIDTH'(int'($urandom_range(0, 24000)) - 12000);
        end
        return near_cut(rank, $urandom_range(0, (1 << rank) - 2),
                        int'($urandom_range(0, 6)) - 3);
    endfunction

    function automatic int order_rank(logic [ORDER_W-1:0] order);
        case (order)
            ORDER_QAM4:  return 1;
            ORDER_QAM16: return 2;
            default:     return 3;
        endcase
    endfunction

    task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] xi,
                               logic signed [SAMPLE_WIDTH-1:0] xq);
        @(negedge i_clk);
        start    <= 1'b1;
        i_sample <= {xi, xq};
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        samples_sent++;
    endtask

    task automatic hold_idle(int n);
        repeat (n) begin
            @(negedge i_clk);
            start    <= 1'b0;
            i_sample <= t_rx_sample'($urandom());
        end
    endtask

    task automatic drain;
        hold_idle(1);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        hold_idle(3);
    endtask

    task automatic apb_transfer(logic write, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {REG_QAM_ORDER, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_order(logic [DATA_W-1:0] data);
        apb_transfer(1'b1, data);
        apb_transfer(1'b0, $urandom());
        orders_seen[data[ORDER_W-1:0]] = 1'b1;
        settings++;
    endtask

    initial begin : stimulus
        logic [ORDER_W-1:0] plan [PHASES];
        logic [ORDER_W-1:0] order;
        int                 left;
        int                 burst;

        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_sample = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset value, then extremes in 4-QAM
        apb_transfer(1'b0, '0);
        set_order(DATA_W'(ORDER_QAM4));
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'shFFFF, 16'sh0000);

        // decision boundaries, ties going to the lower level
        drain();
        set_order(32'hFFFF_FFFC | DATA_W'(ORDER_QAM16));
        for (int j = 0; j < K_QAM16 - 1; j++) begin
            send_sample(near_cut(2, j, 0), near_cut(2, j, 1));
            send_sample(near_cut(2, j, 1), near_cut(2, j, 0));
        end
        drain();
        set_order(DATA_W'(ORDER_QAM64));
        for (int j = 0; j < K_QAM64 - 1; j++) begin
            send_sample(near_cut(3, j, 0), near_cut(3, j, 1));
        end

        // unused order code behaves as 64-QAM
        drain();
        set_order(32'h5555_5557);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);

        plan = '{ORDER_QAM4, ORDER_QAM16, ORDER_QAM64, 2'd3, ORDER_QAM64, ORDER_QAM4,
                 ORDER_W'($urandom_range(0, 3)), ORDER_W'($urandom_range(0, 3))};
        for (int p = 0; p < PHASES; p++) begin
            drain();
            order = plan[p];
            set_order(($urandom() & ~DATA_W'(3)) | DATA_W'(order));
            left = PHASE_LEN;
            while (left > 0) begin
                burst = $urandom_range(1, 16);
                if (burst > left) begin
                    burst = left;
                end
                repeat (burst) begin
                    send_sample(rand_axis(order_rank(order)), rand_axis(order_rank(order)));
                end
                left -= burst;
                if ($urandom_range(0, 3) != 0) begin
                    hold_idle($urandom_range(1, 10));
                end
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("tb: %0d samples sent across %0d register settings, order codes seen %b",
                 samples_sent, settings, orders_seen);
        $display("tb: %0d decisions compared, %0d mismatches, %0d outstanding",
                 decisions, mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
